// ===== src/bums_pkg.sv =====
// shared types and constants of the bottom-up merge sorter
package bums_pkg;

   // width of the value fields on the item channels
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PREP,
      ST_MERGE,
      ST_DRAIN
   } state_type;

endpackage

// ===== src/bums_if.sv =====
// valid/ready channel interfaces for input words and sorted result words
interface bums_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bums_pkg::VALUE_W-1:0]  value;
   logic                                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface bums_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bums_pkg::VALUE_W-1:0]  sorted_value;
   logic                                 final_res;
   logic                                 dropped;

   modport source (output valid, output sorted_value, output final_res, output dropped,
                   input ready);
   modport sink (input valid, input sorted_value, input final_res, input dropped,
                 output ready);
endinterface

// ===== src/bottom_up_merge_sorter_unit.sv =====
// bottom-up merge sorter: loads a batch, merges it between two rams, streams it out sorted
// operation: a word loads per accepted handshake, then ceil(log2(n)) merge passes
//   (setup, then one merged word per cycle); sorted words pass the ram read register
//   and the output register, one per cycle while ready is held; one batch at a time
// reset: synchronous, clears fsm, word count, overflow flag and output valid; rams are not
//   cleared since only entries written in the current batch are read
module bottom_up_merge_sorter_unit #(
   parameter int MAX_ITEMS  = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   bums_req_if.sink   req_chan,
   bums_rsp_if.source rsp_chan
);

   // count width holds 0..MAX_ITEMS, address width indexes the rams,
   // segment math gets two spare bits for lo + 2*width
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int SW = CW + 2;

   // fsm and batch bookkeeping
   bums_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic                src_sel_ff, src_sel_in;   // 0: buffer a is the merge source
   logic [SW-1:0]       width_ff, width_in;

   // merge pointers
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       k_ff, k_in;

   // drain bookkeeping
   logic [CW-1:0]       ocnt_ff, ocnt_in;
   logic                pend_ff, pend_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bums_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                         rsp_final_ff;
   logic                         rsp_dropped_ff;

   // ram ports
   logic                  wr_a_en, wr_b_en;
   logic [AW-1:0]         wr_a_addr;
   logic [DATA_WIDTH-1:0] wr_a_data;
   logic [AW-1:0]         rd_addr0, rd_addr1;
   logic [DATA_WIDTH-1:0] rda0, rda1, rdb0, rdb1;

   // fsm outputs
   logic load_active, prep_active, merge_active, drain_active;

   // handshake and datapath helpers
   logic                  req_fire;
   logic                  has_room;
   logic [CW-1:0]         n_after;
   logic [DATA_WIDTH-1:0] din;
   logic [DATA_WIDTH-1:0] head_l, head_r, merge_data;
   logic                  left_empty, right_empty, take_right;
   logic [CW-1:0]         k_next;
   logic                  seg_end, pass_end;
   logic [SW-1:0]         width_dbl;
   logic                  more_passes;
   logic [CW-1:0]         seg_lo, seg_mid, seg_hi;
   logic [SW-1:0]         sum_mid, sum_hi, n_wide;
   logic                  take, issue, drain_done;

   // incoming value is zero-extended or truncated to the internal width
   assign din      = DATA_WIDTH'($unsigned(req_chan.value));
   assign req_fire = req_chan.valid && req_chan.ready;
   assign has_room = cnt_ff < CW'(MAX_ITEMS);
   assign n_after  = has_room ? cnt_ff + CW'(1) : cnt_ff;

   // ---------------------------------------------------------------
   // merge step: heads are the ram read data for pointers i and j
   // ---------------------------------------------------------------
   assign head_l      = src_sel_ff ? rdb0 : rda0;
   assign head_r      = src_sel_ff ? rdb1 : rda1;
   assign left_empty  = (i_ff == mid_ff);
   assign right_empty = (j_ff == hi_ff);
   // ties take the left run, which keeps the sort stable
   assign take_right  = left_empty ||
                        (!right_empty && ($signed(head_l) > $signed(head_r)));
   assign merge_data  = take_right ? head_r : head_l;
   assign k_next      = k_ff + CW'(1);
   assign seg_end     = (k_next == hi_ff);
   assign pass_end    = seg_end && (hi_ff == cnt_ff);
   assign width_dbl   = width_ff << 1;
   assign n_wide      = SW'(cnt_ff);
   assign more_passes = width_dbl < n_wide;

   // bounds of the next segment pair, clipped to the batch size
   assign seg_lo  = prep_active ? '0 : hi_ff;
   assign sum_mid = SW'(seg_lo) + width_ff;
   assign sum_hi  = SW'(seg_lo) + width_dbl;
   assign seg_mid = (sum_mid > n_wide) ? cnt_ff : sum_mid[CW-1:0];
   assign seg_hi  = (sum_hi > n_wide) ? cnt_ff : sum_hi[CW-1:0];

   // ---------------------------------------------------------------
   // drain: read ahead one word, hold the address while the output stalls
   // ---------------------------------------------------------------
   assign take       = drain_active && pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign issue      = drain_active && (ocnt_ff < cnt_ff) && (!pend_ff || take);
   assign drain_done = drain_active && (ocnt_ff == cnt_ff) && (!pend_ff || take);

   // ---------------------------------------------------------------
   // fsm next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bums_pkg::ST_LOAD: begin
            if (req_fire && req_chan.last) begin
               state_in = (n_after > CW'(1)) ? bums_pkg::ST_PREP : bums_pkg::ST_DRAIN;
            end
         end
         bums_pkg::ST_PREP: begin
            state_in = bums_pkg::ST_MERGE;
         end
         bums_pkg::ST_MERGE: begin
            if (pass_end) begin
               state_in = more_passes ? bums_pkg::ST_PREP : bums_pkg::ST_DRAIN;
            end
         end
         bums_pkg::ST_DRAIN: begin
            if (drain_done) begin
               state_in = bums_pkg::ST_LOAD;
            end
         end
         default: state_in = bums_pkg::ST_LOAD;
      endcase
   end

   // ---------------------------------------------------------------
   // fsm outputs
   // ---------------------------------------------------------------
   always_comb begin
      load_active  = 1'b0;
      prep_active  = 1'b0;
      merge_active = 1'b0;
      drain_active = 1'b0;
      unique case (state_ff)
         bums_pkg::ST_LOAD:  load_active  = 1'b1;
         bums_pkg::ST_PREP:  prep_active  = 1'b1;
         bums_pkg::ST_MERGE: merge_active = 1'b1;
         bums_pkg::ST_DRAIN: drain_active = 1'b1;
         default:            load_active  = 1'b0;
      endcase
   end

   assign req_chan.ready = load_active;

   // ---------------------------------------------------------------
   // datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      src_sel_in = src_sel_ff;
      width_in   = width_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      k_in       = k_ff;
      ocnt_in    = ocnt_ff;
      pend_in    = pend_ff;

      if (load_active) begin
         // drain bookkeeping starts fresh for every batch
         ocnt_in = '0;
         pend_in = 1'b0;
         if (req_fire) begin
            cnt_in = n_after;
            if (!has_room) begin
               ovf_in = 1'b1;
            end
            if (req_chan.last) begin
               width_in   = SW'(1);
               src_sel_in = 1'b0;
            end
         end
      end

      if (prep_active) begin
         i_in   = seg_lo;
         j_in   = seg_mid;
         mid_in = seg_mid;
         hi_in  = seg_hi;
         k_in   = '0;
      end

      if (merge_active) begin
         k_in = k_next;
         if (pass_end) begin
            width_in   = width_dbl;
            src_sel_in = !src_sel_ff;
         end else if (seg_end) begin
            // chain straight into the next segment pair of this pass
            i_in   = seg_lo;
            j_in   = seg_mid;
            mid_in = seg_mid;
            hi_in  = seg_hi;
         end else if (take_right) begin
            j_in = j_ff + CW'(1);
         end else begin
            i_in = i_ff + CW'(1);
         end
      end

      if (drain_active) begin
         if (issue) begin
            ocnt_in = ocnt_ff + CW'(1);
            pend_in = 1'b1;
         end else if (take) begin
            pend_in = 1'b0;
         end
         if (drain_done) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   // output register valid: a word loads on take, leaves on accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // ram port steering
   // ---------------------------------------------------------------
   assign wr_a_en   = (req_fire && has_room) || (merge_active && src_sel_ff);
   assign wr_b_en   = merge_active && !src_sel_ff;
   assign wr_a_addr = merge_active ? k_ff[AW-1:0] : cnt_ff[AW-1:0];
   assign wr_a_data = merge_active ? merge_data : din;

   always_comb begin
      rd_addr0 = i_in[AW-1:0];
      rd_addr1 = j_in[AW-1:0];
      if (prep_active) begin
         rd_addr0 = seg_lo[AW-1:0];
         rd_addr1 = seg_mid[AW-1:0];
      end else if (drain_active) begin
         // next word on issue, otherwise hold the word already read
         rd_addr0 = issue ? ocnt_ff[AW-1:0] : ocnt_in[AW-1:0] - AW'(1);
      end
   end

   bums_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_buf_a (
      .clock    (clock),
      .wr_en    (wr_a_en),
      .wr_addr  (wr_a_addr),
      .wr_data  (wr_a_data),
      .rd_addr0 (rd_addr0),
      .rd_data0 (rda0),
      .rd_addr1 (rd_addr1),
      .rd_data1 (rda1)
   );

   bums_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_buf_b (
      .clock    (clock),
      .wr_en    (wr_b_en),
      .wr_addr  (k_ff[AW-1:0]),
      .wr_data  (merge_data),
      .rd_addr0 (rd_addr0),
      .rd_data0 (rdb0),
      .rd_addr1 (rd_addr1),
      .rd_data1 (rdb1)
   );

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bums_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         ocnt_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         ocnt_ff      <= ocnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_sel_ff <= src_sel_in;
      width_ff   <= width_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      k_ff       <= k_in;
      if (take) begin
         // the word in the ram read register is element ocnt - 1
         rsp_value_ff   <= bums_pkg::VALUE_W'($unsigned(head_l));
         rsp_final_ff   <= (ocnt_ff == cnt_ff);
         rsp_dropped_ff <= ovf_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = $signed(rsp_value_ff);
   assign rsp_chan.final_res    = rsp_final_ff;
   assign rsp_chan.dropped      = rsp_dropped_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // merge pointers stay inside their runs
   a_ptr_bounds: assert property (@(posedge clock) disable iff (reset)
      merge_active |-> (i_ff <= mid_ff) && (j_ff <= hi_ff))
      else $error("merge pointer past its run");

   // every word written consumed exactly one head
   a_ptr_sum: assert property (@(posedge clock) disable iff (reset)
      merge_active |-> (SW'(k_ff) + SW'(mid_ff) == SW'(i_ff) + SW'(j_ff)))
      else $error("merge write index out of step with read pointers");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_ITEMS))
      else $error("word count above capacity");

   a_drain_cnt: assert property (@(posedge clock) disable iff (reset)
      drain_active |-> (ocnt_ff <= cnt_ff))
      else $error("drain read beyond batch");

   // a read-ahead word never survives the drain phase
   a_pend_drain: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> drain_active)
      else $error("pending read outside drain");

endmodule

// ===== src/bums_ram.sv =====
// generic ram, one write port and two registered read ports
module bums_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr0,
   output logic [WIDTH-1:0]          rd_data0,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr1,
   output logic [WIDTH-1:0]          rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

// ===== verif/tb_bottom_up_merge_sorter_unit.sv =====
// testbench of the bottom-up merge sorter: random batches checked against a stable-sort predictor
module tb_bottom_up_merge_sorter_unit;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 500000;
   // long enough to cover loading and sorting of a 20-word batch with room to spare
   localparam int HOLD_CYCLES = 300;
   // slack after the predictor empties; a batch close is the only thing that makes results
   localparam int DRAIN_SLACK = 8;

   typedef logic signed [bums_pkg::VALUE_W-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      final_res;
      logic      dropped;
   } sorted_word_type;

   // collects each batch and predicts the sorted words that its closing word releases
   class sorter_scoreboard;
      value_type       batch[$];
      bit              overflow;
      sorted_word_type sorted_q[$];
      int              errors;

      task report_mismatch(string what, logic [bums_pkg::VALUE_W-1:0] got,
                           logic [bums_pkg::VALUE_W-1:0] want);
         $display("tb: mismatch on %s: got %08h, want %08h", what, got, want);
         errors++;
      endtask

      function void note_word(value_type v, logic l);
         value_type       ordered[$];
         value_type       key;
         sorted_word_type w;
         int              j;
         // words beyond capacity are lost but still mark the batch
         if (batch.size() < CAPACITY) begin
            batch.push_back(v);
         end else begin
            overflow = 1'b1;
         end
         if (!l) return;
         ordered = batch;
         // insertion sort on strict greater-than keeps equal values in arrival order
         for (int i = 1; i < ordered.size(); i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key) begin
               ordered[j + 1] = ordered[j];
               j--;
            end
            ordered[j + 1] = key;
         end
         for (int k = 0; k < ordered.size(); k++) begin
            w.value     = ordered[k];
            w.final_res = (k == ordered.size() - 1);
            w.dropped   = overflow;
            sorted_q.push_back(w);
         end
         batch.delete();
         overflow = 1'b0;
      endfunction

      task check_word(value_type v, logic f, logic d);
         sorted_word_type want;
         if (sorted_q.size() == 0) begin
            report_mismatch("word with nothing pending", v, '0);
            return;
         end
         want = sorted_q.pop_front();
         if (v !== want.value) report_mismatch("sorted_value", v, want.value);
         if (f !== want.final_res) report_mismatch("final_res", f, want.final_res);
         if (d !== want.dropped) report_mismatch("dropped", d, want.dropped);
      endtask

      function int pending();
         return sorted_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   bums_req_if       req_chan ();
   bums_rsp_if       rsp_chan ();
   sorter_scoreboard sb;
   int               req_idle_pct;
   int               rsp_idle_pct;
   bit               hold_request;
   int               cycles;
   value_type        directed[$];

   bottom_up_merge_sorter_unit #(
      .MAX_ITEMS  (CAPACITY),
      .DATA_WIDTH (bums_pkg::VALUE_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // offer one word, with random idle cycles before it, and wait for its handshake
   task automatic send_word(value_type v, logic l);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= v;
      req_chan.last  <= l;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_word(v, l);
   endtask

   task automatic send_list(value_type vals[$]);
      foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
   endtask

   // extremes, a narrow band that makes duplicates likely, or any 32-bit value
   function automatic value_type pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2, 3, 4: return value_type'($urandom_range(15)) - 8;
         default: return value_type'($urandom);
      endcase
   endfunction

   // mostly short batches, some up to capacity and a few at or over it
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(8, 1);
      if (r < 85) return $urandom_range(32, 9);
      if (r < 95) return $urandom_range(64, 33);
      return $urandom_range(68, 64);
   endfunction

   task automatic send_batch(int len);
      for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
   endtask

   task automatic send_random(int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = pick_length();
         send_batch(len);
         sent += len;
      end
   endtask

   // stop offering words and let every pending sorted word come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // result side: check each accepted word, then pick the next ready value
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_word(rsp_chan.sorted_value, rsp_chan.final_res, rsp_chan.dropped);
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      sb = new();
      req_idle_pct = 33;
      rsp_idle_pct = 45;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.value <= '0;
      req_chan.last  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: single-word batch, the two extremes, mixed signs, duplicates, reversed order
      directed = '{value_type'(42)};
      send_list(directed);
      directed = '{32'sh7fff_ffff, 32'sh8000_0000};
      send_list(directed);
      directed = '{value_type'(0), value_type'(-1), value_type'(1), 32'sh8000_0000,
                   32'sh7fff_ffff};
      send_list(directed);
      directed = '{value_type'(5), value_type'(5), value_type'(-3), value_type'(5),
                   value_type'(-3)};
      send_list(directed);
      directed = '{value_type'(100), value_type'(50), value_type'(7), value_type'(0),
                   value_type'(-7), value_type'(-50), value_type'(-100), value_type'(-1000)};
      send_list(directed);

      // sender idles less than the receiver
      send_random(16);
      wait_drained();

      // roles swapped; first starve the result side while the next batch waits at the input behind it
      req_idle_pct = 45;
      rsp_idle_pct = 33;
      hold_request = 1'b1;
      send_batch(20);
      send_batch(20);
      send_random(16);
      wait_drained();

      // no idling: a full batch, one that loses its closing word, then random batches
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_batch(CAPACITY);
      send_batch(CAPACITY + 1);
      send_random(16);
      wait_drained();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
